// ===== rtl/ffa_pkg.sv =====
// Shared types and constants for the first-fit heap allocator.
package ffa_pkg;

    localparam int REQ_W    = 20;
    localparam int OFF_W    = 19;
    localparam int STATUS_W = 3;
    localparam int NEED_W   = 21;

    typedef logic [STATUS_W-1:0] t_status;

    localparam t_status ST_OK          = 3'd0;
    localparam t_status ST_OOM         = 3'd1;
    localparam t_status ST_NOT_FOUND   = 3'd2;
    localparam t_status ST_DOUBLE_FREE = 3'd3;
    localparam t_status ST_NULL        = 3'd4;

    typedef struct packed {
        logic we;
        logic re;
    } t_mem_ctl;

endpackage

// ===== rtl/ffa_hdr_mem.sv =====
// Header store: one entry per 8-byte granule, entry zero reads as the whole free arena after reset.
module ffa_hdr_mem #(
    parameter int ARENA_BYTES  = 524288,
    parameter int HEADER_BYTES = 40
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  ffa_pkg::t_mem_ctl                      i_ctl,
    input  logic [$clog2((ARENA_BYTES+7)/8)-1:0]   i_addr,
    input  logic [$clog2(ARENA_BYTES)+1:0]         i_wdata,
    output logic [$clog2(ARENA_BYTES)+1:0]         o_rdata
);
    localparam int SW    = $clog2(ARENA_BYTES) + 1;
    localparam int EW    = SW + 1;
    localparam int DEPTH = (ARENA_BYTES + 7) / 8;
    localparam int IW    = $clog2(DEPTH);
    localparam logic [EW-1:0] RESET_ENTRY = {SW'(ARENA_BYTES - HEADER_BYTES), 1'b1};

    logic [EW-1:0] r_mem [DEPTH];
    logic [EW-1:0] r_rdata;
    logic          r_rd_zero;
    logic          r_zero_wr;

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_ctl.re) begin
            r_rdata   <= r_mem[i_addr];
            r_rd_zero <= (i_addr == IW'(0));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_wr <= 1'b0;
        end else if (i_ctl.we && i_addr == IW'(0)) begin
            r_zero_wr <= 1'b1;
        end
    end

    assign o_rdata = (r_rd_zero && !r_zero_wr) ? RESET_ENTRY : r_rdata;

endmodule

// ===== rtl/ffa_seq.sv =====
// Sequencer that walks block headers for allocate and free; the walk and the merge scan share the next-header adder.
module ffa_seq #(
    parameter int ARENA_BYTES  = 524288,
    parameter int HEADER_BYTES = 40
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_start,
    input  logic                                   i_kind,
    input  logic [ffa_pkg::REQ_W-1:0]              i_request_bytes,
    input  logic [ffa_pkg::OFF_W-1:0]              i_release_offset,
    input  logic                                   i_done_ack,
    input  logic [$clog2(ARENA_BYTES)+1:0]         i_rd_entry,
    output logic                                   o_idle,
    output logic                                   o_done,
    output logic [ffa_pkg::OFF_W-1:0]              o_granted,
    output ffa_pkg::t_status                       o_status,
    output ffa_pkg::t_mem_ctl                      o_ctl,
    output logic [$clog2((ARENA_BYTES+7)/8)-1:0]   o_addr,
    output logic [$clog2(ARENA_BYTES)+1:0]         o_wdata
);
    localparam int SW    = $clog2(ARENA_BYTES) + 1;
    localparam int AW    = SW + 1;
    localparam int IW    = $clog2((ARENA_BYTES + 7) / 8);
    localparam int NW    = ffa_pkg::NEED_W;
    localparam int CW    = ((AW > NW) ? AW : NW) + 1;
    localparam logic [AW-1:0] ARENA = AW'(ARENA_BYTES);
    localparam logic [AW-1:0] HDR   = AW'(HEADER_BYTES);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_EV   = 3'd2;
    localparam logic [2:0] S_SPL  = 3'd3;
    localparam logic [2:0] S_CRD  = 3'd4;
    localparam logic [2:0] S_CEV  = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0]              r_state, n_state;
    logic                    r_kind, n_kind;
    logic [NW-1:0]           r_need, n_need;
    logic [ffa_pkg::OFF_W-1:0] r_ptr, n_ptr;
    logic [AW-1:0]           r_h, n_h;
    logic [AW-1:0]           r_end, n_end;
    logic [AW-1:0]           r_start, n_start;
    logic [AW-1:0]           r_run_start, n_run_start;
    logic                    r_in_run, n_in_run;
    logic [SW-1:0]           r_wsz, n_wsz;
    logic [ffa_pkg::OFF_W-1:0] r_granted, n_granted;
    ffa_pkg::t_status        r_status, n_status;

    logic [SW-1:0] e_sz;
    logic          e_free;
    logic [AW-1:0] base, nxt, hdr_c, spl_at;
    logic [CW-1:0] sz_c, need_c;
    logic          fit, match;
    logic [SW-1:0] coal_sz;

    assign e_sz    = i_rd_entry[SW:1];
    assign e_free  = i_rd_entry[0];
    assign base    = (r_state == S_CEV) ? r_end : r_h;
    assign nxt     = base + HDR + AW'(e_sz);
    assign hdr_c   = r_h + HDR;
    assign spl_at  = hdr_c + AW'(r_need);
    assign sz_c    = CW'(e_sz);
    assign need_c  = CW'(r_need);
    assign fit     = e_free && (sz_c == need_c || sz_c > need_c + CW'(HEADER_BYTES));
    assign match   = (CW'(hdr_c) == CW'(r_ptr));
    assign coal_sz = SW'(r_end - r_start - HDR);

    always_comb begin
        n_state     = r_state;
        n_kind      = r_kind;
        n_need      = r_need;
        n_ptr       = r_ptr;
        n_h         = r_h;
        n_end       = r_end;
        n_start     = r_start;
        n_run_start = r_run_start;
        n_in_run    = r_in_run;
        n_wsz       = r_wsz;
        n_granted   = r_granted;
        n_status    = r_status;
        o_ctl       = '0;
        o_addr      = IW'(r_h >> 3);
        o_wdata     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_kind    = i_kind;
                    n_need    = (NW'(i_request_bytes) + NW'(7)) & ~NW'(7);
                    n_ptr     = i_release_offset;
                    n_h       = '0;
                    n_in_run  = 1'b0;
                    n_granted = '0;
                    if (i_kind && i_release_offset == '0) begin
                        n_status = ffa_pkg::ST_NULL;
                        n_state  = S_DONE;
                    end else begin
                        n_state = S_RD;
                    end
                end
            end
            S_RD: begin
                if (r_h >= ARENA) begin
                    n_status = r_kind ? ffa_pkg::ST_NOT_FOUND : ffa_pkg::ST_OOM;
                    n_state  = S_DONE;
                end else begin
                    o_ctl.re = 1'b1;
                    n_state  = S_EV;
                end
            end
            S_EV: begin
                if (!r_kind) begin
                    if (fit) begin
                        o_ctl.we  = 1'b1;
                        o_wdata   = {SW'(r_need), 1'b0};
                        n_granted = ffa_pkg::OFF_W'(hdr_c);
                        n_status  = ffa_pkg::ST_OK;
                        n_end     = spl_at;
                        n_wsz     = SW'(sz_c - need_c - CW'(HEADER_BYTES));
                        n_state   = (sz_c != need_c) ? S_SPL : S_DONE;
                    end else begin
                        n_h     = nxt;
                        n_state = S_RD;
                    end
                end else if (match) begin
                    if (e_free) begin
                        n_status = ffa_pkg::ST_DOUBLE_FREE;
                        n_state  = S_DONE;
                    end else begin
                        n_start = r_in_run ? r_run_start : r_h;
                        n_end   = nxt;
                        n_state = S_CRD;
                    end
                end else begin
                    if (e_free) begin
                        if (!r_in_run) begin
                            n_run_start = r_h;
                            n_in_run    = 1'b1;
                        end
                    end else begin
                        n_in_run = 1'b0;
                    end
                    n_h     = nxt;
                    n_state = S_RD;
                end
            end
            S_SPL: begin
                o_ctl.we = 1'b1;
                o_addr   = IW'(r_end >> 3);
                o_wdata  = {r_wsz, 1'b1};
                n_state  = S_DONE;
            end
            S_CRD: begin
                if (r_end >= ARENA) begin
                    o_ctl.we = 1'b1;
                    o_addr   = IW'(r_start >> 3);
                    o_wdata  = {coal_sz, 1'b1};
                    n_status = ffa_pkg::ST_OK;
                    n_state  = S_DONE;
                end else begin
                    o_ctl.re = 1'b1;
                    o_addr   = IW'(r_end >> 3);
                    n_state  = S_CEV;
                end
            end
            S_CEV: begin
                if (e_free) begin
                    n_end   = nxt;
                    n_state = S_CRD;
                end else begin
                    o_ctl.we = 1'b1;
                    o_addr   = IW'(r_start >> 3);
                    o_wdata  = {coal_sz, 1'b1};
                    n_status = ffa_pkg::ST_OK;
                    n_state  = S_DONE;
                end
            end
            S_DONE: begin
                if (i_done_ack) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_in_run <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_in_run <= n_in_run;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind      <= n_kind;
        r_need      <= n_need;
        r_ptr       <= n_ptr;
        r_h         <= n_h;
        r_end       <= n_end;
        r_start     <= n_start;
        r_run_start <= n_run_start;
        r_wsz       <= n_wsz;
        r_granted   <= n_granted;
        r_status    <= n_status;
    end

    assign o_idle    = (r_state == S_IDLE);
    assign o_done    = (r_state == S_DONE);
    assign o_granted = r_granted;
    assign o_status  = r_status;

    a_no_rw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ctl.we && o_ctl.re)) else $error("Header store read and written together.");
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_DONE) |-> !o_ctl.we && !o_ctl.re)
        else $error("Header store accessed outside a walk.");
    a_ev_in_arena: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EV |-> r_h < ARENA) else $error("Header read past the arena.");
    a_split_after_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SPL |-> $past(r_state) == S_EV && !r_kind)
        else $error("Split write without a grant.");

endmodule

// ===== rtl/first_fit_heap_allocator_top.sv =====
// Top level of the first-fit heap allocator with its output register.
//
//   channel | valid  | ready  | payload
//   input   | i_valid| o_ready| i_kind, i_request_bytes, i_release_offset
//   output  | o_valid| i_ready| o_granted_offset, o_status
//
// A word visits block headers in turn, through a read state and an evaluate state each, and a
// free also reads each free block that follows; the single-port header store serializes these.
// After reset entry zero reads as one free arena, so no clearing pass is run.
// A finished word waits in the output register while the next input word is taken.
// While the output register is full and not read, the finished word holds the sequencer.
module first_fit_heap_allocator_top #(
    parameter int ARENA_BYTES  = 524288,
    parameter int HEADER_BYTES = 40
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic                            i_kind,
    input  logic [ffa_pkg::REQ_W-1:0]       i_request_bytes,
    input  logic [ffa_pkg::OFF_W-1:0]       i_release_offset,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [ffa_pkg::OFF_W-1:0]       o_granted_offset,
    output logic [ffa_pkg::STATUS_W-1:0]    o_status
);
    localparam int EW = $clog2(ARENA_BYTES) + 2;
    localparam int IW = $clog2((ARENA_BYTES + 7) / 8);

    ffa_pkg::t_mem_ctl         mem_ctl;
    logic [IW-1:0]             mem_addr;
    logic [EW-1:0]             mem_wdata, mem_rdata;
    logic                      seq_idle, seq_done, done_ack;
    logic [ffa_pkg::OFF_W-1:0] seq_granted;
    ffa_pkg::t_status          seq_status;
    logic                      r_valid;
    logic [ffa_pkg::OFF_W-1:0] r_granted;
    ffa_pkg::t_status          r_status;

    assign o_ready  = seq_idle;
    assign done_ack = seq_done && (!r_valid || i_ready);

    ffa_seq #(.ARENA_BYTES(ARENA_BYTES), .HEADER_BYTES(HEADER_BYTES)) u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_valid && seq_idle),
        .i_kind          (i_kind),
        .i_request_bytes (i_request_bytes),
        .i_release_offset(i_release_offset),
        .i_done_ack      (done_ack),
        .i_rd_entry      (mem_rdata),
        .o_idle          (seq_idle),
        .o_done          (seq_done),
        .o_granted       (seq_granted),
        .o_status        (seq_status),
        .o_ctl           (mem_ctl),
        .o_addr          (mem_addr),
        .o_wdata         (mem_wdata)
    );

    ffa_hdr_mem #(.ARENA_BYTES(ARENA_BYTES), .HEADER_BYTES(HEADER_BYTES)) u_mem (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (mem_ctl),
        .i_addr (mem_addr),
        .i_wdata(mem_wdata),
        .o_rdata(mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (done_ack) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done_ack) begin
            r_granted <= seq_granted;
            r_status  <= seq_status;
        end
    end

    assign o_valid          = r_valid;
    assign o_granted_offset = r_granted;
    assign o_status         = r_status;

endmodule
